// ===== hdl/task_priority_scheduler_defines.svh =====
// Assertion helpers for the task scheduler.
`ifndef TASK_PRIORITY_SCHEDULER_DEFINES_SVH
`define TASK_PRIORITY_SCHEDULER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define TPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define TPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/tps_pkg.sv =====
`timescale 1ns / 1ps
package tps_pkg;
	localparam logic [1:0] MODE_FCFS = 2'd0;
	localparam logic [1:0] MODE_PRIO = 2'd1;
	localparam logic [1:0] MODE_SJF  = 2'd2;
	localparam logic [1:0] MODE_EDF  = 2'd3;

	localparam logic OP_SUBMIT   = 1'b0;
	localparam logic OP_DISPATCH = 1'b1;

	localparam logic [2:0] KIND_ACCEPTED = 3'd0;
	localparam logic [2:0] KIND_REJECTED = 3'd1;
	localparam logic [2:0] KIND_ASSIGNED = 3'd2;
	localparam logic [2:0] KIND_DROPPED  = 3'd3;
	localparam logic [2:0] KIND_EMPTY    = 3'd4;

	// Classified command from the front end to the back end.
	typedef struct packed {
		logic        op;
		logic [1:0]  worker;
		logic [15:0] client;
		logic [31:0] opa;
		logic [31:0] opb;
		logic [15:0] run_time;
		logic [31:0] due;
		logic [31:0] key;
		logic        tail;
		logic [30:0] now;
	} cmd_t;

	// Stored task.
	typedef struct packed {
		logic [31:0] key;
		logic [31:0] opa;
		logic [31:0] opb;
		logic [15:0] client;
		logic [15:0] run_time;
		logic [31:0] due;
		logic [30:0] arrival;
	} entry_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [1:0]  worker;
		logic [15:0] client;
		logic [31:0] opa;
		logic [31:0] opb;
		logic [31:0] sum;
		logic [15:0] run_time;
		logic [30:0] wait_t;
		logic        last;
	} result_t;
endpackage

// ===== hdl/tps_front.sv =====
`timescale 1ns / 1ps
module tps_front #(
	parameter int WORKERS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [193:0]       in_data,
	input  logic [1:0]         mode,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output tps_pkg::cmd_t      cmd
);
	localparam int DW = 2;
	tps_pkg::cmd_t cmd_q [DW];
	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	tps_pkg::cmd_t c;
	logic drop;

	always_comb begin
		c.op       = in_data[0];
		c.worker   = in_data[2:1];
		c.client   = in_data[18:3];
		c.opa      = in_data[50:19];
		c.opb      = in_data[82:51];
		c.run_time = in_data[98:83];
		c.due      = in_data[130:99];
		c.now      = in_data[193:163];
		c.tail     = (mode == tps_pkg::MODE_FCFS);
		case (mode)
			tps_pkg::MODE_PRIO: c.key = in_data[162:131];
			tps_pkg::MODE_SJF:  c.key = {16'd0, in_data[98:83]};
			tps_pkg::MODE_EDF:  c.key = in_data[130:99];
			default:            c.key = '0;
		endcase
	end

	// drop dispatches to workers that do not exist
	assign drop     = (c.op == tps_pkg::OP_DISPATCH) && (32'(c.worker) >= WORKERS);
	assign in_ready = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = cmd_q[rd_q];

	wire push = in_valid && in_ready && !drop;
	wire pop  = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) cmd_q[wr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; wr_q <= 1'b0; rd_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== hdl/tps_back.sv =====
`timescale 1ns / 1ps
`include "task_priority_scheduler_defines.svh"
module tps_back #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         mode,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  tps_pkg::cmd_t      cmd,
	output logic               res_valid,
	input  logic               res_ready,
	output tps_pkg::result_t   res
);
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_SHIFT = 3'd2;
	localparam logic [2:0] ST_POP   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;
	localparam logic [2:0] ST_PREP  = 3'd5;

	tps_pkg::entry_t mem [QUEUE_DEPTH];
	logic [2:0]    st_q;
	logic [CW-1:0] count_q, idx_q, pos_q;
	logic [AW-1:0] hd_q;
	tps_pkg::cmd_t cur_q;
	tps_pkg::result_t res_q;
	logic          res_v_q;
	tps_pkg::entry_t rd_q;
	logic          more_q;
	logic          res_done;

	assign cmd_ready = (st_q == ST_IDLE) && !res_v_q;
	assign res_valid = res_v_q;
	assign res = res_q;
	assign res_done = res_v_q && res_ready;

	// Circular head; logical slot i is at hd_q + i.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
		logic [AW:0] s;
		s = {1'b0, h} + (AW+1)'(i);
		if (s >= (AW+1)'(QUEUE_DEPTH)) s = s - (AW+1)'(QUEUE_DEPTH);
		return s[AW-1:0];
	endfunction

	function automatic tps_pkg::result_t mk_res(input logic [2:0] k, input logic [1:0] wk,
			input tps_pkg::entry_t e, input logic [31:0] sum, input logic [30:0] wt,
			input logic lst);
		tps_pkg::result_t r;
		r.kind = k; r.worker = wk; r.client = e.client; r.opa = e.opa; r.opb = e.opb;
		r.sum = sum; r.run_time = e.run_time; r.wait_t = wt; r.last = lst;
		return r;
	endfunction

	tps_pkg::entry_t new_e;
	always_comb begin
		new_e.key = cur_q.key; new_e.opa = cur_q.opa; new_e.opb = cur_q.opb;
		new_e.client = cur_q.client; new_e.run_time = cur_q.run_time;
		new_e.due = cur_q.due; new_e.arrival = cur_q.now;
	end

	logic [AW-1:0] ra, wa;
	logic          we;
	tps_pkg::entry_t wd;
	logic [CW-1:0] idxm1, idxm2;
	assign idxm1 = idx_q - 1'b1;
	assign idxm2 = idx_q - CW'(2);

	// rd_q holds entry idx_q-1 in every shift cycle that moves an entry; read one ahead
	always_comb begin
		ra = phys(hd_q, idx_q); we = 1'b0; wa = ra; wd = new_e;
		case (st_q)
			ST_PREP: begin
				ra = phys(hd_q, idxm1);
			end
			ST_SHIFT: begin
				ra = phys(hd_q, idxm2);
				we = 1'b1; wa = phys(hd_q, idx_q);
				if (idx_q == pos_q) wd = new_e;
				else wd = rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[ra];
		if (we) mem[wa] <= wd;
	end

	// wait and deadline
	logic [30:0] waitv;
	logic        late;
	logic [31:0] nowrt;
	always_comb begin
		waitv = (cur_q.now >= rd_q.arrival) ? cur_q.now - rd_q.arrival : '0;
		nowrt = {1'b0, cur_q.now} + {16'd0, rd_q.run_time};
		late  = (mode == tps_pkg::MODE_EDF) &&
		        ($signed({rd_q.due[31], rd_q.due}) < $signed({1'b0, nowrt}));
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && cmd_valid && cmd_ready) cur_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; count_q <= '0; idx_q <= '0; pos_q <= '0;
			hd_q <= '0; res_v_q <= 1'b0; res_q <= '0; more_q <= 1'b0;
		end else begin
			if (res_done && st_q != ST_OUT) res_v_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (cmd_valid && cmd_ready) begin
					idx_q <= '0;
					if (cmd.op == tps_pkg::OP_SUBMIT) begin
						if (count_q == CW'(QUEUE_DEPTH)) begin
							res_q <= mk_res(tps_pkg::KIND_REJECTED, 2'd0, '0, 32'd0, 31'd0,
								1'b1);
							res_v_q <= 1'b1;
						end else if (cmd.tail || count_q == '0) begin
							pos_q <= count_q; idx_q <= count_q; st_q <= ST_SHIFT;
						end else begin
							st_q <= ST_SCAN;
						end
					end else if (count_q == '0) begin
						res_q <= mk_res(tps_pkg::KIND_EMPTY, cmd.worker, '0, 32'd0, 31'd0,
							1'b1);
						res_v_q <= 1'b1;
					end else begin
						st_q <= ST_POP;
					end
				end
				// one stored key a cycle, read data valid for idx_q-1
				ST_SCAN: begin
					if (idx_q != '0 && $signed(rd_q.key) > $signed(cur_q.key)) begin
						pos_q <= idxm1; idx_q <= count_q; st_q <= ST_PREP;
					end else if (idx_q == count_q) begin
						pos_q <= count_q; idx_q <= count_q; st_q <= ST_SHIFT;
					end else idx_q <= idx_q + 1'b1;
				end
				// fetch the tail entry before the first move
				ST_PREP: begin
					st_q <= ST_SHIFT;
				end
				// move entries up from the tail, then write the new one
				ST_SHIFT: begin
					if (idx_q == pos_q) begin
						count_q <= count_q + 1'b1;
						res_q <= mk_res(tps_pkg::KIND_ACCEPTED, 2'd0, '0, 32'd0, 31'd0, 1'b1);
						res_v_q <= 1'b1; st_q <= ST_IDLE;
					end else idx_q <= idxm1;
				end
				// read the head entry; its data is in rd_q in ST_OUT
				ST_POP: begin
					st_q <= ST_OUT;
				end
				ST_OUT: if (!res_v_q || res_ready) begin
					res_v_q <= 1'b1;
					if (more_q) begin
						res_q <= mk_res(tps_pkg::KIND_EMPTY, cur_q.worker, '0, 32'd0, 31'd0,
							1'b1);
						more_q <= 1'b0; st_q <= ST_IDLE;
					end else begin
						hd_q <= phys(hd_q, CW'(1)); count_q <= count_q - 1'b1;
						if (late) begin
							res_q <= mk_res(tps_pkg::KIND_DROPPED, cur_q.worker, rd_q, 32'd0,
								waitv, 1'b0);
							if (count_q == CW'(1)) more_q <= 1'b1;
							else st_q <= ST_POP;
						end else begin
							res_q <= mk_res(tps_pkg::KIND_ASSIGNED, cur_q.worker, rd_q,
								rd_q.opa + rd_q.opb, waitv, 1'b1);
							st_q <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`TPS_ASSERT_IMPL(a_cnt_max, clk, arst_n, 1'b1, count_q <= CW'(QUEUE_DEPTH), "count overflow")
	`TPS_ASSERT_IMPL(a_ready_idle, clk, arst_n, cmd_ready, st_q == ST_IDLE, "ready while busy")
	`TPS_ASSERT_NEXT(a_hold, clk, arst_n, res_v_q && !res_ready, res_v_q && $stable(res_q), "result lost")
endmodule

// ===== hdl/task_priority_scheduler.sv =====
`timescale 1ns / 1ps
// Channel   | Dir | Contents
// s_axis    | in  | tdata: operation, worker_id, client_id, first_operand, second_operand,
//           |     |        run_time, due_time, urgency, now_time
// m_axis    | out | tdata: kind, worker_out, client_out, operand_a_out, operand_b_out,
//           |     |        sum_out, run_time_out, wait_time; tlast: last
// cfg       | in  | strategy_mode, written when cfg_we is high
// After an input transaction a reject or an empty-queue answer is registered straight from
// the idle state, a tail insert goes through one shift step; a sorted insert adds a scan
// step per compared entry, one read-ahead step and one shift step per moved entry.
// A dispatch goes through the pop and output states; each further result of an EDF
// drop chain repeats both; the empty result after a fully dropped queue needs only output.
// arst_n clears the queue count, head pointer, command queue and mode.
// A two-entry command queue decouples intake from the back end; results stall in place.
module task_priority_scheduler #(
	parameter int QUEUE_DEPTH = 16,
	parameter int WORKERS     = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [199:0] s_axis_tdata,  // operation, worker_id, client_id, first_operand,
	                                    // second_operand, run_time, due_time, urgency, now_time
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [167:0] m_axis_tdata,  // kind, worker_out, client_out, operand_a_out,
	                                    // operand_b_out, sum_out, run_time_out, wait_time
	output logic         m_axis_tlast,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_wdata
);
	logic [1:0] mode_q;
	logic cmd_valid, cmd_ready;
	tps_pkg::cmd_t cmd;
	tps_pkg::result_t res;

	// hold the strategy register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= tps_pkg::MODE_FCFS;
		else if (cfg_we) mode_q <= cfg_wdata;
	end

	tps_front #(.WORKERS(WORKERS)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata[193:0]), .mode(mode_q),
		.cmd_valid, .cmd_ready, .cmd
	);

	tps_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk, .arst_n, .mode(mode_q),
		.cmd_valid, .cmd_ready, .cmd,
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
	);

	// pack the result transaction, first field lowest
	assign m_axis_tdata = {4'd0, res.wait_t, res.run_time, res.sum, res.opb, res.opa,
	                       res.client, res.worker, res.kind};
	assign m_axis_tlast = res.last;
endmodule
